// ----- hdl/hierarchical_bitmap_slot_allocator_top_assert.svh -----
// Assertion macros for the hierarchical bitmap slot allocator top level.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef HIERARCHICAL_BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define HIERARCHICAL_BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HBSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HBSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hbsa_pkg.sv -----
// Shared types, constants and bit helpers for the hierarchical bitmap slot allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package hbsa_pkg;

	localparam int FANOUT  = 64;
	localparam int WORD_W  = 64;
	localparam int BIT_W   = 6;
	localparam int SLOT_W  = 18;
	localparam int COUNT_W = 19;
	localparam int CORES_W = 7;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_out;
		status_t           status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_RECALC,
		S_IDLE,
		S_TOP,
		S_MID,
		S_LEAF,
		S_FREE,
		S_FREE_UPD,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear_step;
		logic top_eval;
		logic mid_eval;
		logic leaf_eval;
		logic free_chk;
		logic free_upd;
		logic ld_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic div_busy;
		logic req_free;
		logic top_full;
		logic mid_zero;
		logic leaf_zero;
		logic range_bad;
		logic out_free;
	} sts_t;

	// Index of the lowest set bit; 63 for an empty word.
	function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] n;
		n = BIT_W'(WORD_W - 1);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				n = BIT_W'(i);
			end
		end
		return n;
	endfunction

	// One-hot word with bit n set.
	function automatic logic [WORD_W-1:0] bit_of(input logic [BIT_W-1:0] n);
		return {{(WORD_W-1){1'b0}}, 1'b1} << n;
	endfunction

endpackage

// ----- hdl/hbsa_ctrl.sv -----
// Controller state machine of the hierarchical bitmap slot allocator.
// Depends on hbsa_pkg for the state, command and status types.
module hbsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic           cfg_we,
	input  hbsa_pkg::sts_t sts,
	output hbsa_pkg::cmd_t cmd
);
	import hbsa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   ready;
	state_t start_state;

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// First state of a newly accepted transaction.
	assign start_state = sts.req_free ? S_FREE : S_TOP;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = S_RECALC;
				end
			end
			S_RECALC: begin
				if (!sts.div_busy && !cfg_we) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cfg_we) begin
					state_nxt = S_RECALC;
				end else if (req_valid) begin
					state_nxt = start_state;
				end
			end
			S_TOP: begin
				state_nxt = sts.top_full ? S_RESULT : S_MID;
			end
			S_MID: begin
				state_nxt = sts.mid_zero ? S_TOP : S_LEAF;
			end
			S_LEAF: begin
				state_nxt = sts.leaf_zero ? S_MID : S_RESULT;
			end
			S_FREE: begin
				state_nxt = sts.range_bad ? S_RESULT : S_FREE_UPD;
			end
			S_FREE_UPD: begin
				state_nxt = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					if (cfg_we) begin
						state_nxt = S_RECALC;
					end else if (req_valid) begin
						state_nxt = start_state;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs: handshake and datapath commands.
	always_comb begin
		ready = !cfg_we &&
			((state_q == S_IDLE) || ((state_q == S_RESULT) && sts.out_free));
		req_stall      = !ready;
		cmd.accept     = ready && req_valid;
		cmd.clear_step = (state_q == S_CLEAR);
		cmd.top_eval   = (state_q == S_TOP);
		cmd.mid_eval   = (state_q == S_MID);
		cmd.leaf_eval  = (state_q == S_LEAF);
		cmd.free_chk   = (state_q == S_FREE);
		cmd.free_upd   = (state_q == S_FREE_UPD);
		cmd.ld_out     = (state_q == S_RESULT) && sts.out_free;
	end

endmodule

// ----- hdl/hbsa_datapath.sv -----
// Datapath of the hierarchical bitmap slot allocator: bitmap levels, counters,
// remainder unit and result registers. Depends on hbsa_pkg.
module hbsa_datapath #(
	parameter int TOP_WORDS = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hbsa_pkg::CORES_W-1:0]  cfg_wdata,
	input  hbsa_pkg::req_t                req_data,
	input  hbsa_pkg::cmd_t                cmd,
	output hbsa_pkg::sts_t                sts,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output hbsa_pkg::rsp_t                rsp_data
);
	import hbsa_pkg::*;

	localparam int MID_WORDS  = TOP_WORDS * FANOUT;
	localparam int LEAF_WORDS = MID_WORDS * FANOUT;
	localparam int MID_AW     = $clog2(MID_WORDS);
	localparam int LEAF_AW    = MID_AW + BIT_W;
	localparam int TW_AW      = (TOP_WORDS > 1) ? $clog2(TOP_WORDS) : 1;
	localparam int LIMIT_W    = COUNT_W + 2;
	localparam int PROD_W     = CORES_W + 2;
	localparam int DIV_CW     = $clog2(COUNT_W);
	localparam logic [LIMIT_W-1:0] SLOT_LIMIT = LIMIT_W'(MID_WORDS * FANOUT * FANOUT);

	// Configuration, count and remainder state.
	logic [CORES_W-1:0] cores_q;
	logic [COUNT_W-1:0] count_q;
	logic [CORES_W-1:0] rem_q;
	logic               step_one_q;
	logic               div_busy_q;
	logic [DIV_CW-1:0]  div_cnt_q;
	logic [CORES_W-1:0] div_r_q;
	logic [LEAF_AW-1:0] clr_cnt_q;

	// Summary and leaf bitmaps.
	logic [TOP_WORDS-1:0][WORD_W-1:0] top_q;
	logic [WORD_W-1:0] mid_mem [MID_WORDS];
	logic [WORD_W-1:0] leaf_mem [LEAF_WORDS];
	logic [WORD_W-1:0] mid_rd_q;
	logic [WORD_W-1:0] leaf_rd_q;

	// Per-transaction payload registers.
	req_t               req_q;
	logic [TW_AW-1:0]   w_q;
	logic [BIT_W-1:0]   b1_q;
	logic [BIT_W-1:0]   b2_q;
	logic [MID_AW-1:0]  m_q;
	logic [LEAF_AW-1:0] l_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	// Combinational signals.
	logic [CORES_W-1:0]   cores_eff;
	logic [CORES_W-1:0]   step_w;
	logic [TOP_WORDS-1:0] top_nz;
	logic [TOP_WORDS-1:0] stride_hit;
	logic [TW_AW-1:0]     w_s;
	logic [TW_AW-1:0]     w_f;
	logic [TW_AW-1:0]     w_sel;
	logic [WORD_W-1:0]    top_sel;
	logic                 found_s;
	logic                 over_limit;
	logic                 at_limit;
	logic                 top_full;
	logic [BIT_W-1:0]     b1;
	logic [MID_AW-1:0]    m_next;
	logic                 mid_zero;
	logic                 leaf_zero;
	logic [BIT_W-1:0]     b2;
	logic [BIT_W-1:0]     b3;
	logic [SLOT_W-1:0]    f_slot;
	logic [LEAF_AW-1:0]   f_l;
	logic [MID_AW-1:0]    f_m;
	logic [BIT_W-1:0]     f_mbit;
	logic                 range_bad;
	logic                 dbl;
	logic                 alloc_ok;
	logic                 free_ok;
	logic                 count_max;
	logic [CORES_W-1:0]   rem_p1;
	logic [CORES_W-1:0]   rem_inc;
	logic [CORES_W-1:0]   rem_dec;
	logic [CORES_W:0]     div_shift;
	logic [CORES_W-1:0]   div_next;
	logic                 div_fin;
	logic                 mid_we;
	logic [MID_AW-1:0]    mid_waddr;
	logic [WORD_W-1:0]    mid_wdata;
	logic                 mid_re;
	logic [MID_AW-1:0]    mid_raddr;
	logic                 mid_patch;
	logic                 leaf_we;
	logic [LEAF_AW-1:0]   leaf_waddr;
	logic [WORD_W-1:0]    leaf_wdata;
	logic                 leaf_re;
	logic [LEAF_AW-1:0]   leaf_raddr;

	// A core count of zero behaves as one; after a fallback the scan steps by one.
	assign cores_eff = (cores_q == '0) ? CORES_W'(1) : cores_q;
	assign step_w    = step_one_q ? CORES_W'(1) : cores_eff;

	// Mark the top words that lie on the strided scan path and hold free bits.
	always_comb begin : top_scan
		logic [CORES_W-1:0] diff;
		logic               on_path;
		top_nz     = '0;
		stride_hit = '0;
		for (int i = 0; i < TOP_WORDS; i++) begin
			top_nz[i] = |top_q[i];
			diff      = CORES_W'(i) - rem_q;
			on_path   = 1'b0;
			for (int k = 0; k < TOP_WORDS; k++) begin
				if (PROD_W'(diff) == PROD_W'(k) * PROD_W'(step_w)) begin
					on_path = 1'b1;
				end
			end
			stride_hit[i] = top_nz[i] && (CORES_W'(i) >= rem_q) && on_path;
		end
	end

	// Pick the first word on the strided path, else the first nonzero word.
	always_comb begin
		w_s = '0;
		w_f = '0;
		for (int i = TOP_WORDS - 1; i >= 0; i--) begin
			if (stride_hit[i]) begin
				w_s = TW_AW'(i);
			end
			if (top_nz[i]) begin
				w_f = TW_AW'(i);
			end
		end
	end

	assign found_s    = |stride_hit;
	assign over_limit = LIMIT_W'(count_q) > SLOT_LIMIT;
	assign at_limit   = LIMIT_W'(count_q) >= SLOT_LIMIT;
	assign top_full   = over_limit || (!found_s && (at_limit || !(|top_nz)));
	assign w_sel      = found_s ? w_s : w_f;

	// Select the chosen top word.
	always_comb begin
		top_sel = '0;
		for (int i = 0; i < TOP_WORDS; i++) begin
			if (TW_AW'(i) == w_sel) begin
				top_sel = top_q[i];
			end
		end
	end

	assign b1     = low_bit(top_sel);
	assign m_next = MID_AW'({w_sel, b1});

	// Descent through the mid and leaf words.
	assign mid_zero  = (mid_rd_q == '0);
	assign leaf_zero = (leaf_rd_q == '0);
	assign b2        = low_bit(mid_rd_q);
	assign b3        = low_bit(leaf_rd_q);

	// Free request decode; an 18-bit slot always lands in top word zero.
	assign f_slot    = req_q.slot_in;
	assign f_l       = LEAF_AW'(f_slot[SLOT_W-1:BIT_W]);
	assign f_m       = MID_AW'(f_slot[SLOT_W-1:2*BIT_W]);
	assign f_mbit    = f_slot[2*BIT_W-1:BIT_W];
	assign range_bad = LIMIT_W'(f_slot) >= SLOT_LIMIT;
	assign dbl       = leaf_rd_q[f_slot[BIT_W-1:0]];

	assign alloc_ok  = cmd.leaf_eval && !leaf_zero;
	assign free_ok   = cmd.free_upd && !dbl;

	// Incremental upkeep of count mod cores.
	assign count_max = &count_q;
	assign rem_p1    = rem_q + CORES_W'(1);
	assign rem_inc   = (count_max || (rem_p1 == cores_eff)) ? '0 : rem_p1;
	assign rem_dec   = (rem_q == '0) ? (cores_eff - CORES_W'(1)) : (rem_q - CORES_W'(1));

	// One restoring remainder step per cycle, most significant count bit first.
	assign div_shift = {div_r_q, count_q[div_cnt_q]};
	assign div_next  = (div_shift >= {1'b0, cores_eff}) ?
		CORES_W'(div_shift - {1'b0, cores_eff}) : CORES_W'(div_shift);
	assign div_fin   = div_busy_q && !cfg_we && (div_cnt_q == '0);

	// Mid memory port selection.
	always_comb begin
		mid_we    = 1'b0;
		mid_waddr = m_q;
		mid_wdata = '1;
		if (cmd.clear_step) begin
			mid_we    = clr_cnt_q < LEAF_AW'(MID_WORDS);
			mid_waddr = clr_cnt_q[MID_AW-1:0];
			mid_wdata = '1;
		end else if (cmd.leaf_eval && leaf_zero) begin
			mid_we    = 1'b1;
			mid_waddr = m_q;
			mid_wdata = mid_rd_q & ~bit_of(b2_q);
		end else if (free_ok) begin
			mid_we    = 1'b1;
			mid_waddr = f_m;
			mid_wdata = mid_rd_q | bit_of(f_mbit);
		end
		mid_re    = (cmd.top_eval && !top_full) || (cmd.free_chk && !range_bad);
		mid_raddr = cmd.free_chk ? f_m : m_next;
		mid_patch = cmd.leaf_eval && leaf_zero;
	end

	// Leaf memory port selection.
	always_comb begin
		leaf_we    = 1'b0;
		leaf_waddr = l_q;
		leaf_wdata = '1;
		if (cmd.clear_step) begin
			leaf_we    = 1'b1;
			leaf_waddr = clr_cnt_q;
			leaf_wdata = '1;
		end else if (alloc_ok) begin
			leaf_we    = 1'b1;
			leaf_waddr = l_q;
			leaf_wdata = leaf_rd_q & ~bit_of(b3);
		end else if (free_ok) begin
			leaf_we    = 1'b1;
			leaf_waddr = f_l;
			leaf_wdata = leaf_rd_q | bit_of(f_slot[BIT_W-1:0]);
		end
		leaf_re    = (cmd.mid_eval && !mid_zero) || (cmd.free_chk && !range_bad);
		leaf_raddr = cmd.free_chk ? f_l : {m_q, b2};
	end

	// Mid memory; a stale leaf word also clears the bit in the held read word.
	always_ff @(posedge clk) begin
		if (mid_we) begin
			mid_mem[mid_waddr] <= mid_wdata;
		end
		if (mid_re) begin
			mid_rd_q <= mid_mem[mid_raddr];
		end else if (mid_patch) begin
			mid_rd_q <= mid_rd_q & ~bit_of(b2_q);
		end
	end

	// Leaf memory.
	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_waddr] <= leaf_wdata;
		end
		if (leaf_re) begin
			leaf_rd_q <= leaf_mem[leaf_raddr];
		end
	end

	// Configuration, count, remainder and clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cores_q    <= CORES_W'(1);
			count_q    <= '0;
			rem_q      <= '0;
			step_one_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			div_r_q    <= '0;
			clr_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				cores_q    <= cfg_wdata;
				div_busy_q <= 1'b1;
				div_cnt_q  <= DIV_CW'(COUNT_W - 1);
				div_r_q    <= '0;
			end else if (div_busy_q) begin
				div_r_q <= div_next;
				if (div_cnt_q == '0) begin
					div_busy_q <= 1'b0;
				end else begin
					div_cnt_q <= div_cnt_q - DIV_CW'(1);
				end
			end
			if (div_fin) begin
				rem_q <= div_next;
			end else if (alloc_ok) begin
				rem_q <= rem_inc;
			end else if (free_ok && (count_q != '0)) begin
				rem_q <= rem_dec;
			end
			if (alloc_ok) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (free_ok && (count_q != '0)) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (cmd.accept) begin
				step_one_q <= 1'b0;
			end else if (cmd.top_eval && !top_full && !found_s) begin
				step_one_q <= 1'b1;
			end
			if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + LEAF_AW'(1);
			end
		end
	end

	// Top summary words: stale bits clear on descent, frees set them again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '1;
		end else begin
			for (int i = 0; i < TOP_WORDS; i++) begin
				if (cmd.mid_eval && mid_zero && (TW_AW'(i) == w_q)) begin
					top_q[i] <= top_q[i] & ~bit_of(b1_q);
				end else if (free_ok && (i == 0)) begin
					top_q[i] <= top_q[i] | bit_of(f_slot[SLOT_W-1:2*BIT_W]);
				end
			end
		end
	end

	// Transaction payload and result capture.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_data;
		end
		if (cmd.top_eval) begin
			w_q  <= w_sel;
			b1_q <= b1;
			m_q  <= m_next;
			if (top_full) begin
				res_q.slot_out <= '0;
				res_q.status   <= ST_FULL;
			end
		end
		if (cmd.mid_eval) begin
			b2_q <= b2;
			l_q  <= {m_q, b2};
		end
		if (alloc_ok) begin
			res_q.slot_out <= SLOT_W'({l_q, b3});
			res_q.status   <= ST_OK;
		end
		if (cmd.free_chk && range_bad) begin
			res_q.slot_out <= f_slot;
			res_q.status   <= ST_RANGE;
		end
		if (cmd.free_upd) begin
			res_q.slot_out <= f_slot;
			res_q.status   <= dbl ? ST_DOUBLE : ST_OK;
		end
		if (cmd.ld_out) begin
			rsp_q <= res_q;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Status to the controller.
	assign sts.clear_last = (clr_cnt_q == LEAF_AW'(LEAF_WORDS - 1));
	assign sts.div_busy   = div_busy_q;
	assign sts.req_free   = (req_data.operation == OP_FREE);
	assign sts.top_full   = top_full;
	assign sts.mid_zero   = mid_zero;
	assign sts.leaf_zero  = leaf_zero;
	assign sts.range_bad  = range_bad;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

endmodule

// ----- hdl/hierarchical_bitmap_slot_allocator_top.sv -----
// Hierarchical bitmap slot allocator. Allocate: top, mid and leaf steps after acceptance,
// then the output register; a stale summary bit sends the descent back up a level.
// Free: read leaf and mid words, update, output. One transaction at a time;
// the next is accepted as the result loads.
// Reset clears control state, then a pass writes all ones into the mid and leaf memories,
// one word a cycle; a core count write holds requests until the remainder is recomputed.
module hierarchical_bitmap_slot_allocator_top #(
	parameter int TOP_WORDS = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  hbsa_pkg::req_t               req_data,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output hbsa_pkg::rsp_t               rsp_data,
	input  logic                         cfg_we,
	input  logic [hbsa_pkg::CORES_W-1:0] cfg_wdata
);
	import hbsa_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic rsp_full;

	// Sequencer for the scan, descent and free steps.
	hbsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cfg_we    (cfg_we),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Bitmaps, counters and result registers.
	hbsa_datapath #(
		.TOP_WORDS (TOP_WORDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// A full result is on the output.
	assign rsp_full = rsp_valid && (rsp_data.status == ST_FULL);

	`include "hierarchical_bitmap_slot_allocator_top_assert.svh"

	// Only one transaction is in flight.
	`HBSA_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "accepted while busy")
	// A result is loaded only when the output register can take it.
	`HBSA_ASSERT_SAME(a_load_when_free, cmd.ld_out, !rsp_valid || !rsp_stall, "result overwritten")
	// A core count write starts a remainder recompute that holds off requests.
	`HBSA_ASSERT_NEXT(a_cfg_holds_req, cfg_we, req_stall, "request accepted during recompute")
	// A full status carries slot zero.
	`HBSA_ASSERT_SAME(a_full_slot_zero, rsp_full, rsp_data.slot_out == '0, "full with nonzero slot")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the hierarchical bitmap slot allocator top level.
// Tracks its own bitmap copy to predict every allocate and free outcome.
// Depends on hbsa_pkg and hierarchical_bitmap_slot_allocator_top only.
module testbench;
	import hbsa_pkg::*;

	localparam int TOP_WORDS       = 1;
	localparam int SLOT_LIMIT      = TOP_WORDS * FANOUT * FANOUT * FANOUT;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 50000;
	localparam int RANDOM_CHUNKS   = 6;
	localparam int CHUNK_ITEMS     = 270;
	localparam int LEAF_FILL_ITEMS = 160;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	req_t                req_data;
	logic                rsp_valid;
	logic                rsp_stall;
	rsp_t                rsp_data;
	logic                cfg_we;
	logic [CORES_W-1:0]  cfg_wdata;

	// Shadow copy of the allocator state.
	logic [WORD_W-1:0]   top_map  [0:TOP_WORDS-1];
	logic [WORD_W-1:0]   mid_map  [0:TOP_WORDS*FANOUT-1];
	logic [WORD_W-1:0]   leaf_map [0:TOP_WORDS*FANOUT*FANOUT-1];
	logic [COUNT_W-1:0]  live_slots;
	logic [CORES_W-1:0]  core_cfg;

	// Outcomes owed by the block, oldest first, and the slots it has handed out.
	rsp_t                pending_outcomes [$];
	logic [SLOT_W-1:0]   held_slots [$];
	logic [SLOT_W-1:0]   last_released = '0;

	bit                  quiet = 1'b0;
	int                  hold_off_len = 0;
	int                  stall_run = 0;
	int                  fail_count = 0;
	int                  stalled_cycles = 0;

	hierarchical_bitmap_slot_allocator_top #(
		.TOP_WORDS(TOP_WORDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock, period 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Index of the lowest set bit, found by isolating it and encoding its position.
	function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] iso;
		logic [BIT_W-1:0]  n;
		if (w == '0) begin
			n = BIT_W'(WORD_W - 1);
		end else begin
			iso  = w & (~w + 1'b1);
			n[0] = |(iso & 64'hAAAA_AAAA_AAAA_AAAA);
			n[1] = |(iso & 64'hCCCC_CCCC_CCCC_CCCC);
			n[2] = |(iso & 64'hF0F0_F0F0_F0F0_F0F0);
			n[3] = |(iso & 64'hFF00_FF00_FF00_FF00);
			n[4] = |(iso & 64'hFFFF_0000_FFFF_0000);
			n[5] = |(iso & 64'hFFFF_FFFF_0000_0000);
		end
		return n;
	endfunction

	// Return every bitmap level to all free, with the count and core setting at reset.
	function automatic void clear_bitmaps();
		foreach (top_map[i]) top_map[i] = '1;
		foreach (mid_map[i]) mid_map[i] = '1;
		foreach (leaf_map[i]) leaf_map[i] = '1;
		live_slots = '0;
		core_cfg   = CORES_W'(1);
	endfunction

	// Allocation: strided top scan, fallback scan, then descent with lazy summary cleanup.
	function automatic rsp_t take_slot();
		rsp_t             r;
		int unsigned      cores, step, i, w, m, l;
		logic [BIT_W-1:0] b1, b2, b3;
		bit               found, done, descend;
		r.slot_out = '0;
		r.status   = ST_FULL;
		cores = (core_cfg == '0) ? 1 : core_cfg;
		step  = cores;
		done  = (live_slots > SLOT_LIMIT);
		while (!done) begin
			found = 1'b0;
			w     = 0;
			for (i = live_slots % cores; i < TOP_WORDS; i += step) begin
				if (!found && top_map[i] != '0) begin
					found = 1'b1;
					w     = i;
				end
			end
			if (!found) begin
				if (live_slots >= SLOT_LIMIT) begin
					done = 1'b1;
				end else begin
					step = 1;
					for (i = 0; i < TOP_WORDS; i++) begin
						if (!found && top_map[i] != '0) begin
							found = 1'b1;
							w     = i;
						end
					end
					if (!found) done = 1'b1;
				end
			end
			if (!done) begin
				b1      = lowest_one(top_map[w]);
				m       = w * FANOUT + b1;
				descend = 1'b1;
				while (descend) begin
					if (mid_map[m] == '0) begin
						// Stale top bit: drop it and rescan from the top.
						top_map[w][b1] = 1'b0;
						descend        = 1'b0;
					end else begin
						b2 = lowest_one(mid_map[m]);
						l  = m * FANOUT + b2;
						if (leaf_map[l] == '0) begin
							mid_map[m][b2] = 1'b0;
						end else begin
							b3             = lowest_one(leaf_map[l]);
							leaf_map[l][b3] = 1'b0;
							live_slots     = live_slots + 1'b1;
							r.slot_out     = SLOT_W'(l * FANOUT + b3);
							r.status       = ST_OK;
							descend        = 1'b0;
							done           = 1'b1;
						end
					end
				end
			end
		end
		return r;
	endfunction

	// Release: range check, double-free check, then set the leaf and summary bits.
	function automatic rsp_t release_slot(input logic [SLOT_W-1:0] s);
		rsp_t        r;
		int unsigned l, m, w;
		r.slot_out = s;
		if (s >= SLOT_LIMIT) begin
			r.status = ST_RANGE;
		end else begin
			l = s / FANOUT;
			m = l / FANOUT;
			w = m / FANOUT;
			if (leaf_map[l][s % FANOUT]) begin
				r.status = ST_DOUBLE;
			end else begin
				leaf_map[l][s % FANOUT] = 1'b1;
				mid_map[m][l % FANOUT]  = 1'b1;
				top_map[w][m % FANOUT]  = 1'b1;
				if (live_slots != '0) live_slots = live_slots - 1'b1;
				r.status = ST_OK;
			end
		end
		return r;
	endfunction

	// Idle length shared by both sides: mostly none, some short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	// Offer one request transaction and record its predicted outcome once accepted.
	task automatic issue_request(input op_t op, input logic [SLOT_W-1:0] s);
		req_t        item;
		rsp_t        outcome;
		int unsigned gap;
		int          found_at;
		item.operation = op;
		item.slot_in   = s;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (op == OP_ALLOC) begin
			outcome = take_slot();
			if (outcome.status == ST_OK) held_slots.push_back(outcome.slot_out);
		end else begin
			outcome = release_slot(s);
			if (outcome.status == ST_OK) begin
				last_released = s;
				found_at = -1;
				foreach (held_slots[k]) begin
					if (held_slots[k] == s) found_at = k;
				end
				if (found_at >= 0) held_slots.delete(found_at);
			end
		end
		pending_outcomes.push_back(outcome);
	endtask

	// Stop offering and wait until every outstanding transaction has returned.
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Core count writes happen only with the block idle.
	task automatic set_cores(input logic [CORES_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		core_cfg = v;
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [SLOT_W-1:0] any_held();
		if (held_slots.size() == 0) return SLOT_W'($urandom);
		return held_slots[$urandom_range(0, held_slots.size() - 1)];
	endfunction

	// Field extremes, both operations and double frees, from the reset state.
	task automatic test_directed();
		issue_request(OP_ALLOC, '0);
		issue_request(OP_ALLOC, '1);
		issue_request(OP_ALLOC, SLOT_W'($urandom));
		issue_request(OP_FREE, SLOT_W'(1));
		issue_request(OP_FREE, SLOT_W'(1));
		issue_request(OP_FREE, '1);
		issue_request(OP_FREE, '0);
		issue_request(OP_FREE, SLOT_W'(1) << (SLOT_W - 1));
		issue_request(OP_ALLOC, '1);
		issue_request(OP_ALLOC, '0);
		issue_request(OP_ALLOC, '0);
		issue_request(OP_FREE, SLOT_W'(2));
		issue_request(OP_FREE, SLOT_W'(3));
		issue_request(OP_FREE, SLOT_W'(64));
		settle();
	endtask

	// Zero, 64, all-ones and small core counts, a few transactions each.
	task automatic test_core_counts();
		logic [CORES_W-1:0] v;
		for (int k = 0; k < 5; k++) begin
			case (k)
				0: v = '0;
				1: v = CORES_W'(64);
				2: v = '1;
				3: v = CORES_W'(2);
				default: v = CORES_W'(1);
			endcase
			set_cores(v);
			issue_request(OP_ALLOC, SLOT_W'($urandom));
			issue_request(OP_ALLOC, SLOT_W'($urandom));
			issue_request(OP_FREE, any_held());
			issue_request(OP_ALLOC, SLOT_W'($urandom));
		end
		settle();
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		quiet        = 1'b1;
		hold_off_len = 300;
		for (int k = 0; k < 24; k++) begin
			if (k % 3 == 2) begin
				issue_request(OP_FREE, any_held());
			end else begin
				issue_request(OP_ALLOC, SLOT_W'($urandom));
			end
		end
		quiet = 1'b0;
		settle();
	endtask

	// Mostly allocations and frees of held slots, with random and repeated frees mixed in.
	task automatic test_random_mix();
		int unsigned roll;
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			case (chunk)
				0: set_cores(CORES_W'(1));
				1: set_cores(CORES_W'(64));
				2: set_cores('0);
				default: set_cores(CORES_W'($urandom_range(1, 64)));
			endcase
			quiet = (chunk == 3);
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 50 || held_slots.size() == 0) begin
					issue_request(OP_ALLOC, SLOT_W'($urandom));
				end else if (roll < 85) begin
					issue_request(OP_FREE, any_held());
				end else if (roll < 95) begin
					issue_request(OP_FREE, SLOT_W'($urandom));
				end else begin
					issue_request(OP_FREE, last_released);
				end
			end
		end
		quiet = 1'b0;
		settle();
	endtask

	// Allocate through several more leaf words so stale summary bits get cleared,
	// then free and refill a few.
	task automatic test_leaf_word_fill();
		set_cores(CORES_W'(5));
		quiet = 1'b1;
		repeat (LEAF_FILL_ITEMS) issue_request(OP_ALLOC, SLOT_W'($urandom));
		issue_request(OP_ALLOC, '1);
		issue_request(OP_ALLOC, '0);
		quiet = 1'b0;
		issue_request(OP_FREE, '1);
		issue_request(OP_FREE, '0);
		repeat (4) issue_request(OP_FREE, any_held());
		issue_request(OP_FREE, '0);
		repeat (8) issue_request(OP_ALLOC, SLOT_W'($urandom));
		set_cores('0);
		issue_request(OP_ALLOC, SLOT_W'($urandom));
		repeat (3) issue_request(OP_FREE, SLOT_W'($urandom));
		repeat (4) issue_request(OP_ALLOC, SLOT_W'($urandom));
		settle();
	endtask

	// Receiver stall pattern, with a long hold-off when one is requested.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
				rsp_stall <= 1'b0;
			end else if (stall_run != 0) begin
				stall_run--;
			end else begin
				stall_run = pick_gap();
				if (stall_run == 0) begin
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= 1'b1;
					stall_run--;
				end
			end
		end
	end

	// Compare each accepted result transaction with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result: slot_out %0d status %0d",
					rsp_data.slot_out, rsp_data.status);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_data.slot_out !== want.slot_out) begin
					$error("slot_out mismatch: expected %0d, actual %0d",
						want.slot_out, rsp_data.slot_out);
					fail_count++;
				end
				if (rsp_data.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, rsp_data.status);
					fail_count++;
				end
			end
		end
	end

	// End the run if no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Reset, run every test in turn, then report.
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		clear_bitmaps();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_core_counts();
		test_backpressure();
		test_random_mix();
		test_leaf_word_fill();
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/hbsa_pkg.sv
hdl/hbsa_ctrl.sv
hdl/hbsa_datapath.sv
hdl/hierarchical_bitmap_slot_allocator_top.sv
tb/sv/testbench.sv
